// ===== hdl/ewarc_pkg.sv =====
`timescale 1ns / 1ps

package ewarc_pkg;

    localparam int WINDOW_DEPTH = 5;

    localparam int CFG_W      = 24;
    localparam int WIDTH_W    = 32;
    localparam int REP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W      = CFG_W + CNT_W;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LOW       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_HIGH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_THRESHOLD = 3'd4;

    localparam logic [CFG_W-1:0] RANGE_LIMIT_RST      = 24'd881600;
    localparam logic [CFG_W-1:0] REJECT_LOW_RST       = 24'd100;
    localparam logic [CFG_W-1:0] REJECT_HIGH_RST      = 24'd400000;
    localparam logic [CFG_W-1:0] TOP_THRESHOLD_RST    = 24'd140000;
    localparam logic [CFG_W-1:0] BOTTOM_THRESHOLD_RST = 24'd120000;

    typedef struct packed {
        logic              latch_in;
        logic              check;
        logic              sum_step;
        logic [IDX_W-1:0]  sum_idx;
        logic              mult;
        logic              div_step;
        logic              decide;
        logic              load_out;
    } ewarc_cmd_t;

    typedef struct packed {
        logic out_of_range;
        logic n_zero;
    } ewarc_status_t;

endpackage

// ===== hdl/ewarc_ctrl.sv =====
`timescale 1ns / 1ps

module ewarc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ewarc_pkg::ewarc_status_t status,
    output ewarc_pkg::ewarc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_MULT,
        ST_DIV,
        ST_DECIDE,
        ST_OUTPUT
    } state_t;

    state_t                      state_reg;
    logic [ewarc_pkg::STEP_W-1:0] cnt_reg;
    logic                        out_valid_reg;
    logic                        out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.latch_in = (state_reg == ST_IDLE) && s_valid;
        cmd.check    = (state_reg == ST_CHECK);
        cmd.sum_step = (state_reg == ST_SUM);
        cmd.sum_idx  = cnt_reg[ewarc_pkg::IDX_W-1:0];
        cmd.mult     = (state_reg == ST_MULT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.decide   = (state_reg == ST_DECIDE);
        cmd.load_out = (state_reg == ST_OUTPUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_OUTPUT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    cnt_reg <= '0;
                    if (status.out_of_range) begin
                        state_reg <= ST_OUTPUT;
                    end else begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (cnt_reg == ewarc_pkg::STEP_W'(ewarc_pkg::WINDOW_DEPTH - 1)) begin
                        state_reg <= ST_MULT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_MULT: begin
                    cnt_reg <= ewarc_pkg::STEP_W'(ewarc_pkg::SUM_W - 1);
                    // empty window falls back to the raw width, no divide
                    if (status.n_zero) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DECIDE: begin
                    state_reg <= ST_OUTPUT;
                end
                ST_OUTPUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/ewarc_dp.sv =====
`timescale 1ns / 1ps

module ewarc_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [ewarc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ewarc_pkg::CFG_W-1:0]          cfg_data,
    input  logic [ewarc_pkg::WIDTH_W-1:0]        s_pulse_width,
    input  logic                                 s_clear_count,
    input  ewarc_pkg::ewarc_cmd_t                cmd,
    output ewarc_pkg::ewarc_status_t             status,
    output logic [ewarc_pkg::WIDTH_W-1:0]        m_filtered_width,
    output logic [ewarc_pkg::REP_W-1:0]          m_rep_count,
    output logic                                 m_phase_up,
    output logic                                 m_in_range
);

    localparam int CFG_W = ewarc_pkg::CFG_W;
    localparam int CNT_W = ewarc_pkg::CNT_W;
    localparam int SUM_W = ewarc_pkg::SUM_W;
    localparam int WW    = ewarc_pkg::WIDTH_W;

    logic [CFG_W-1:0] range_limit_reg;
    logic [CFG_W-1:0] reject_low_reg;
    logic [CFG_W-1:0] reject_high_reg;
    logic [CFG_W-1:0] top_thr_reg;
    logic [CFG_W-1:0] bot_thr_reg;

    logic [CFG_W-1:0]            window_reg [ewarc_pkg::WINDOW_DEPTH];
    logic [ewarc_pkg::IDX_W-1:0] slot_reg;
    logic                        lifted_reg;
    logic [ewarc_pkg::REP_W-1:0] rep_reg;

    logic [WW-1:0]    width_reg;
    logic             clear_reg;
    logic             oor_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] n_reg;
    logic [SUM_W-1:0] bot_prod_reg;
    logic [SUM_W-1:0] top_prod_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [WW-1:0]    avg_reg;

    logic             out_of_range;
    logic             in_window;
    logic [CNT_W:0]   trial;
    logic             trial_ge;
    logic             below;
    logic             above;

    assign out_of_range = width_reg > {{(WW - CFG_W){1'b0}}, range_limit_reg};
    assign in_window    = (width_reg > {{(WW - CFG_W){1'b0}}, reject_low_reg})
                       && (width_reg < {{(WW - CFG_W){1'b0}}, reject_high_reg});

    assign status.out_of_range = out_of_range;
    assign status.n_zero       = (n_reg == '0);

    // restoring divide, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, n_reg};

    always_comb begin
        if (n_reg == '0) begin
            below = width_reg < {{(WW - CFG_W){1'b0}}, bot_thr_reg};
            above = width_reg > {{(WW - CFG_W){1'b0}}, top_thr_reg};
        end else begin
            below = sum_reg < bot_prod_reg;
            above = sum_reg > top_prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_limit_reg <= ewarc_pkg::RANGE_LIMIT_RST;
            reject_low_reg  <= ewarc_pkg::REJECT_LOW_RST;
            reject_high_reg <= ewarc_pkg::REJECT_HIGH_RST;
            top_thr_reg     <= ewarc_pkg::TOP_THRESHOLD_RST;
            bot_thr_reg     <= ewarc_pkg::BOTTOM_THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ewarc_pkg::REG_RANGE_LIMIT:      range_limit_reg <= cfg_data;
                ewarc_pkg::REG_REJECT_LOW:       reject_low_reg  <= cfg_data;
                ewarc_pkg::REG_REJECT_HIGH:      reject_high_reg <= cfg_data;
                ewarc_pkg::REG_TOP_THRESHOLD:    top_thr_reg     <= cfg_data;
                ewarc_pkg::REG_BOTTOM_THRESHOLD: bot_thr_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ewarc_pkg::WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
            slot_reg   <= '0;
            lifted_reg <= 1'b0;
            rep_reg    <= '0;
        end else begin
            if (cmd.check) begin
                if (clear_reg) begin
                    rep_reg <= '0;
                end
                if (!out_of_range && in_window) begin
                    window_reg[slot_reg] <= width_reg[CFG_W-1:0];
                    if (slot_reg == ewarc_pkg::IDX_W'(ewarc_pkg::WINDOW_DEPTH - 1)) begin
                        slot_reg <= '0;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
            end
            if (cmd.decide) begin
                priority if (!lifted_reg && below) begin
                    lifted_reg <= 1'b1;
                end else if (lifted_reg && above) begin
                    lifted_reg <= 1'b0;
                    if (rep_reg != ewarc_pkg::REP_MAX) begin
                        rep_reg <= rep_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            width_reg <= s_pulse_width;
            clear_reg <= s_clear_count;
        end
        if (cmd.check) begin
            oor_reg <= out_of_range;
            sum_reg <= '0;
            n_reg   <= '0;
        end
        if (cmd.sum_step && (window_reg[cmd.sum_idx] != '0)) begin
            sum_reg <= sum_reg + {{CNT_W{1'b0}}, window_reg[cmd.sum_idx]};
            n_reg   <= n_reg + CNT_W'(1);
        end
        if (cmd.mult) begin
            bot_prod_reg <= {{CNT_W{1'b0}}, bot_thr_reg} * {{CFG_W{1'b0}}, n_reg};
            top_prod_reg <= {{CNT_W{1'b0}}, top_thr_reg} * {{CFG_W{1'b0}}, n_reg};
            quo_reg      <= sum_reg;
            rem_reg      <= '0;
        end
        if (cmd.div_step) begin
            if (trial_ge) begin
                rem_reg <= CNT_W'(trial - {1'b0, n_reg});
            end else begin
                rem_reg <= trial[CNT_W-1:0];
            end
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
        end
        if (cmd.decide) begin
            if (n_reg == '0) begin
                avg_reg <= width_reg;
            end else begin
                avg_reg <= {{(WW - SUM_W){1'b0}}, quo_reg};
            end
        end
        if (cmd.load_out) begin
            m_filtered_width <= oor_reg ? '0 : avg_reg;
            m_rep_count      <= rep_reg;
            m_phase_up       <= lifted_reg;
            m_in_range       <= !oor_reg;
        end
    end

endmodule

// ===== hdl/echo_window_average_rep_counter_top.sv =====
`timescale 1ns / 1ps
// an accepted word steps through check, window sum, multiply, divide, decide and
// output; out of range words go straight to output and an empty window skips the
// divide; the window sum takes one entry a cycle, the restoring divider one bit a cycle
// one word in flight: the next word is taken in the cycle after the result registers
// synchronous active-low reset restores register defaults, empties the window,
// clears phase and count

module echo_window_average_rep_counter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ewarc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ewarc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ewarc_pkg::WIDTH_W-1:0]     s_pulse_width,
    input  logic                              s_clear_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ewarc_pkg::WIDTH_W-1:0]     m_filtered_width,
    output logic [ewarc_pkg::REP_W-1:0]       m_rep_count,
    output logic                              m_phase_up,
    output logic                              m_in_range
);

    ewarc_pkg::ewarc_cmd_t    cmd;
    ewarc_pkg::ewarc_status_t status;

    assign cfg_ready = 1'b1;

    ewarc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ewarc_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_pulse_width    (s_pulse_width),
        .s_clear_count    (s_clear_count),
        .cmd              (cmd),
        .status           (status),
        .m_filtered_width (m_filtered_width),
        .m_rep_count      (m_rep_count),
        .m_phase_up       (m_phase_up),
        .m_in_range       (m_in_range)
    );

    // out of range words report a zero width
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_filtered_width == '0)
        else $error("out of range word with nonzero width");

    // busy after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_valid || m_ready)
        else $error("result register overwritten");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CFG_W        = ewarc_pkg::CFG_W;
    localparam int WIDTH_W      = ewarc_pkg::WIDTH_W;
    localparam int REP_W        = ewarc_pkg::REP_W;
    localparam int CFG_IDX_W    = ewarc_pkg::CFG_IDX_W;
    localparam int WINDOW_DEPTH = ewarc_pkg::WINDOW_DEPTH;

    localparam int CLK_PERIOD   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int SAT_PAIRS    = 40;
    localparam logic [CFG_W-1:0] CFG_ALL_ONES = {CFG_W{1'b1}};

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [REP_W-1:0]   reps;
        logic               lifted;
        logic               in_range;
    } echo_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [WIDTH_W-1:0]   s_pulse_width;
    logic                 s_clear_count;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [WIDTH_W-1:0]   m_filtered_width;
    logic [REP_W-1:0]     m_rep_count;
    logic                 m_phase_up;
    logic                 m_in_range;

    // shadow copy of the block's registers and state
    logic [CFG_W-1:0] lim_range, win_low, win_high, thr_top, thr_bottom;
    logic [CFG_W-1:0] win_entries [WINDOW_DEPTH];
    int               win_slot;
    logic             phase_lifted;
    logic [REP_W-1:0] rep_tally;

    echo_result_t echo_results_due [$];
    echo_result_t due;

    bit idle_on = 1'b0;
    int hold_requested = 0;
    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int in_range_seen = 0;
    int out_range_seen = 0;
    int phase_flips = 0;
    logic [REP_W-1:0] peak_reps = '0;
    logic prev_phase = 1'b0;

    echo_window_average_rep_counter_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pulse_width    (s_pulse_width),
        .s_clear_count    (s_clear_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_width (m_filtered_width),
        .m_rep_count      (m_rep_count),
        .m_phase_up       (m_phase_up),
        .m_in_range       (m_in_range)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic reset_echo_model();
        lim_range    = ewarc_pkg::RANGE_LIMIT_RST;
        win_low      = ewarc_pkg::REJECT_LOW_RST;
        win_high     = ewarc_pkg::REJECT_HIGH_RST;
        thr_top      = ewarc_pkg::TOP_THRESHOLD_RST;
        thr_bottom   = ewarc_pkg::BOTTOM_THRESHOLD_RST;
        for (int i = 0; i < WINDOW_DEPTH; i++) win_entries[i] = '0;
        win_slot     = 0;
        phase_lifted = 1'b0;
        rep_tally    = '0;
    endtask

    task automatic predict_echo(input logic [WIDTH_W-1:0] pw, input logic clr);
        echo_result_t r;
        logic [63:0]  total;
        logic [63:0]  cnt;
        logic         below, above;
        if (clr) rep_tally = '0;
        r.reps   = rep_tally;
        r.lifted = phase_lifted;
        if (pw > {8'h00, lim_range}) begin
            r.width    = '0;
            r.in_range = 1'b0;
            echo_results_due.push_back(r);
            return;
        end
        if (pw > {8'h00, win_low} && pw < {8'h00, win_high}) begin
            win_entries[win_slot] = pw[CFG_W-1:0];
            win_slot = (win_slot + 1) % WINDOW_DEPTH;
        end
        total = '0;
        cnt   = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (win_entries[i] != '0) begin
                total += win_entries[i];
                cnt   += 1;
            end
        end
        // empty window falls back to the raw width
        if (cnt == 0) begin
            r.width = pw;
            below   = pw < {8'h00, thr_bottom};
            above   = pw > {8'h00, thr_top};
        end else begin
            r.width = WIDTH_W'(total / cnt);
            below   = total < {40'h0, thr_bottom} * cnt;
            above   = total > {40'h0, thr_top} * cnt;
        end
        if (!phase_lifted && below) begin
            phase_lifted = 1'b1;
        end else if (phase_lifted && above) begin
            phase_lifted = 1'b0;
            if (rep_tally != ewarc_pkg::REP_MAX) rep_tally = rep_tally + 1'b1;
        end
        r.reps     = rep_tally;
        r.lifted   = phase_lifted;
        r.in_range = 1'b1;
        echo_results_due.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // mostly widths that push the window mean across the active threshold
    function automatic logic [WIDTH_W-1:0] pick_width();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom;
        if (r < 20) begin
            case ($urandom_range(0, 9))
                0: return '0;
                1: return {WIDTH_W{1'b1}};
                2: return {8'h00, win_low};
                3: return {8'h00, win_low} + 1;
                4: return {8'h00, win_high} - 1;
                5: return {8'h00, win_high};
                6: return {8'h00, lim_range};
                7: return {8'h00, lim_range} + 1;
                8: return {8'h00, thr_top};
                default: return {8'h00, thr_bottom};
            endcase
        end
        if (phase_lifted) begin
            span = (thr_top >> 3) + 16;
            return thr_top + $urandom_range(0, span);
        end
        span = (thr_bottom >> 3) + 16;
        if (thr_bottom > span) return thr_bottom - $urandom_range(0, span);
        return $urandom_range(0, thr_bottom);
    endfunction

    task automatic send_word(input logic [WIDTH_W-1:0] pw, input logic clr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pulse_width <= pw;
        s_clear_count <= clr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_echo(pw, clr);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            ewarc_pkg::REG_RANGE_LIMIT:      lim_range  = data;
            ewarc_pkg::REG_REJECT_LOW:       win_low    = data;
            ewarc_pkg::REG_REJECT_HIGH:      win_high   = data;
            ewarc_pkg::REG_TOP_THRESHOLD:    thr_top    = data;
            ewarc_pkg::REG_BOTTOM_THRESHOLD: thr_bottom = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // an unused index goes first each time, it must leave the registers alone
    task automatic program_regs(input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] lo,
                                input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] top,
                                input logic [CFG_W-1:0] bot);
        write_reg(CFG_IDX_W'(ewarc_pkg::REG_BOTTOM_THRESHOLD + 1 + $urandom_range(0, 2)),
                  CFG_W'($urandom));
        write_reg(ewarc_pkg::REG_RANGE_LIMIT, rl);
        write_reg(ewarc_pkg::REG_REJECT_LOW, lo);
        write_reg(ewarc_pkg::REG_REJECT_HIGH, hi);
        write_reg(ewarc_pkg::REG_TOP_THRESHOLD, top);
        write_reg(ewarc_pkg::REG_BOTTOM_THRESHOLD, bot);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_defaults();
        program_regs(ewarc_pkg::RANGE_LIMIT_RST, ewarc_pkg::REJECT_LOW_RST,
                     ewarc_pkg::REJECT_HIGH_RST, ewarc_pkg::TOP_THRESHOLD_RST,
                     ewarc_pkg::BOTTOM_THRESHOLD_RST);
    endtask

    task automatic program_ordered(input bit wide);
        int unsigned lo, hi, bot, top, rl;
        lo  = wide ? 0 : $urandom_range(0, 5000);
        hi  = wide ? CFG_ALL_ONES : $urandom_range(lo + 100000, CFG_ALL_ONES);
        bot = $urandom_range(lo + 1, hi / 2);
        top = $urandom_range(bot, hi - 1);
        rl  = wide ? CFG_ALL_ONES : $urandom_range(hi, CFG_ALL_ONES);
        program_regs(CFG_W'(rl), CFG_W'(lo), CFG_W'(hi), CFG_W'(top), CFG_W'(bot));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (echo_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // window stays empty, so every in-range word compares its raw width; each pair counts one
    task automatic test_rep_counting();
        wait_idle();
        program_regs(CFG_ALL_ONES, CFG_ALL_ONES, '0, ewarc_pkg::TOP_THRESHOLD_RST,
                     ewarc_pkg::BOTTOM_THRESHOLD_RST);
        idle_on = 1'b0;
        for (int i = 0; i < SAT_PAIRS; i++) begin
            send_word('0, 1'b0);
            send_word(WIDTH_W'(CFG_ALL_ONES), 1'b0);
        end
        send_word('0, 1'b1);
        send_word(WIDTH_W'(CFG_ALL_ONES), 1'b1);
        send_word({WIDTH_W{1'b1}}, 1'b1);
    endtask

    task automatic test_limits_and_window();
        wait_idle();
        program_defaults();
        idle_on = 1'b1;
        send_word({WIDTH_W{1'b1}}, 1'b0);
        send_word(32'd881601, 1'b1);
        send_word(32'd881600, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'd100, 1'b0);
        send_word(32'd400000, 1'b0);
        send_word(32'd101, 1'b0);
        send_word(32'd399999, 1'b0);
        send_word(32'd150000, 1'b0);
        send_word(32'd150000, 1'b0);
        send_word(32'd130000, 1'b0);
        send_word(32'd120000, 1'b0);
        send_word(32'd125000, 1'b0);
        send_word(32'd10000, 1'b0);
        send_word(32'd10000, 1'b0);
        send_word(32'd399999, 1'b1);
        send_word(32'h0100_0000, 1'b1);
        send_word(32'h00FF_FFFF, 1'b0);
        send_word(32'd399999, 1'b0);
        send_word(32'd399999, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        program_regs('0, '0, '0, '0, '0);
        send_word('0, 1'b0);
        send_word(32'd1, 1'b0);
        send_word('0, 1'b1);
        send_word({WIDTH_W{1'b1}}, 1'b0);
        wait_idle();
        program_regs(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
        send_word(32'h00FF_FFFE, 1'b0);
        send_word(32'h00FF_FFFF, 1'b0);
        send_word(32'h0100_0000, 1'b1);
        send_word(32'd1, 1'b0);
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 6; k++) begin
            wait_idle();
            case (k)
                0: program_defaults();
                3: program_ordered(1'b1);
                4: program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                CFG_W'($urandom), CFG_W'($urandom));
                default: program_ordered(1'b0);
            endcase
            idle_on = (k != 1);
            repeat (125) send_word(pick_width(), $urandom_range(0, 19) == 0);
        end
    endtask

    // sink holds off while words keep coming, block must stall its input
    task automatic test_output_backpressure();
        wait_idle();
        program_defaults();
        idle_on = 1'b0;
        hold_requested++;
        repeat (12) send_word(pick_width(), 1'b0);
        idle_on = 1'b1;
    endtask

    initial begin : sink_ready
        int stall_left;
        int hold_served;
        stall_left  = 0;
        hold_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_requested != hold_served) begin
                hold_served = hold_requested;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90)
                                                          : $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (echo_results_due.size() == 0) begin
                $display("%0t: result with nothing due, width %0d", $time, m_filtered_width);
                mismatches++;
            end else begin
                due = echo_results_due.pop_front();
                if (m_filtered_width !== due.width) begin
                    $display("%0t: filtered_width expected %0d actual %0d",
                             $time, due.width, m_filtered_width);
                    mismatches++;
                end
                if (m_rep_count !== due.reps) begin
                    $display("%0t: rep_count expected %0d actual %0d",
                             $time, due.reps, m_rep_count);
                    mismatches++;
                end
                if (m_phase_up !== due.lifted) begin
                    $display("%0t: phase_up expected %0b actual %0b",
                             $time, due.lifted, m_phase_up);
                    mismatches++;
                end
                if (m_in_range !== due.in_range) begin
                    $display("%0t: in_range expected %0b actual %0b",
                             $time, due.in_range, m_in_range);
                    mismatches++;
                end
                if (due.in_range) in_range_seen++;
                else out_range_seen++;
                if (due.lifted != prev_phase) phase_flips++;
                prev_phase = due.lifted;
                if (due.reps > peak_reps) peak_reps = due.reps;
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_pulse_width = '0;
        s_clear_count = 1'b0;
        reset_echo_model();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_rep_counting();
        test_limits_and_window();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();

        $display("words in %0d, results checked %0d (%0d in range, %0d out of range)",
                 words_sent, results_checked, in_range_seen, out_range_seen);
        $display("phase changes %0d, highest repetition count %0d, register sets incl. extremes",
                 phase_flips, peak_reps);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ewarc_pkg.sv
hdl/ewarc_ctrl.sv
hdl/ewarc_dp.sv
hdl/echo_window_average_rep_counter_top.sv
tb/tb.sv
